### rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared constants, widths and the arctangent table for the go-to-goal block.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int GUARD_BITS    = 8;
    localparam int ANGLE_FRAC    = 30;

    localparam int XW  = 28;
    localparam int ZW  = 36;
    localparam int MBW = 30;
    localparam int MPW = XW + MBW;

    localparam int TABLE_LEN = 24;
    localparam int IDXW      = 5;

    localparam int ONE_I     = 1 << FRACTION_BITS;
    localparam int DIST_MIN_I = (ONE_I + 5) / 10;
    localparam int ERR_MIN_I  = (ONE_I * 2 + 5) / 10;
    localparam int DIST_SH   = ANGLE_FRAC + GUARD_BITS;
    localparam int ERR_SH    = ANGLE_FRAC - FRACTION_BITS;
    localparam int DISTW     = MPW + 1 - DIST_SH;
    localparam int ERRW      = ZW + 1 - ERR_SH;

    localparam logic [15:0]           ONE       = 16'(ONE_I);
    localparam logic [DISTW-1:0]      DIST_MIN  = DISTW'(DIST_MIN_I);
    localparam logic [ERRW-1:0]       ERR_MIN   = ERRW'(ERR_MIN_I);
    localparam logic signed [16:0]    GOAL_LIM  = 17'sd49152;
    localparam logic signed [ZW-1:0]  PI_Q30    = 36'sd3373259426;
    localparam logic [MBW-1:0]        INV_GAIN  = 30'd652032875;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;

    function automatic logic [30:0] atan_q30(input logic [IDXW-1:0] i);
        logic [30:0] v;
        case (i)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/gtg_smul.sv
// ----------------------------------------------------------------------------
// gtg_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gtg_smul import gtg_pkg::*; #(
    parameter int AW = 28,
    parameter int BW = 30
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int CW = $clog2(AW + 1);

    logic [AW+BW-1:0] p_reg, p_next;
    logic [BW-1:0]    b_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [BW:0]      sum;

    always_comb begin
        sum      = {1'b0, p_reg[AW+BW-1:AW]} + (p_reg[0] ? {1'b0, b_reg} : '0);
        p_next   = p_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            p_next   = {{BW{1'b0}}, a};
            cnt_next = CW'(AW);
        end else if (cnt_reg != '0) begin
            p_next   = {sum, p_reg[AW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        p_reg <= p_next;
        if (start) begin
            b_reg <= b;
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

### rtl/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative CORDIC vectoring, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module gtg_cordic import gtg_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    output logic                 done,
    output logic [XW-1:0]        mag,
    output logic signed [ZW-1:0] angle
);

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next, at;
    logic [IDXW-1:0]      i_reg, i_next;
    logic                 busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = ZW'(atan_q30(i_reg));
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            i_next = '0;
            busy_next = 1'b1;
            if (x_in < 0) begin
                x_next = -x_in;
                y_next = -y_in;
                z_next = (y_in >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg < 0) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == IDXW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    assign done  = done_reg;
    assign mag   = x_reg;
    assign angle = z_reg;

endmodule

### rtl/go_to_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller
// Flow: a set-target beat goes straight to ST_DONE; a pose beat runs the CORDIC,
//   then one distance multiply (ST_MUL1), and when driving a second speed
//   multiply (ST_MUL2), before ST_DONE loads the result into the output register.
// One beat in flight; next beat accepted the cycle after the result is loaded.
// ST_DONE waits while the output register still holds an unaccepted result.
// Synchronous active-low reset: gain, limit and goal return to 1.0.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller import gtg_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // pose_x, pose_y, pose_heading, request_x, request_y
    input  logic        s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // linear_speed, turn_rate, accepted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [15:0] gain_reg, limit_reg, goal_x_reg, goal_y_reg;
    logic [15:0] goal_x_next, goal_y_next;
    logic signed [14:0] hd_reg;
    logic [ERRW-1:0]    err_reg, err_next;
    logic [31:0] res_reg, res_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic signed [16:0] rx, ry, dx, dy;
    logic signed [XW-1:0] cx, cy;
    logic                 c_start, c_done;
    logic [XW-1:0]        c_mag;
    logic signed [ZW-1:0] c_ang, err_s, err_a;
    logic [ZW:0]          err_rnd;
    logic                 mul_start, mul_done;
    logic [XW-1:0]        mul_a;
    logic [MBW-1:0]       mul_b;
    logic [MPW-1:0]       mul_p;
    logic [MPW:0]         dist_sum, spd_sum;
    logic [MPW-FRACTION_BITS:0] spd;

    assign rx = s_tdata[63:47];
    assign ry = s_tdata[80:64];
    assign dx = $signed({1'b0, goal_x_reg}) - $signed({1'b0, s_tdata[15:0]});
    assign dy = $signed({1'b0, goal_y_reg}) - $signed({1'b0, s_tdata[31:16]});
    assign cx = XW'(dx) <<< GUARD_BITS;
    assign cy = XW'(dy) <<< GUARD_BITS;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(c_start), .x_in(cx), .y_in(cy),
        .done(c_done), .mag(c_mag), .angle(c_ang)
    );

    gtg_smul #(.AW(XW), .BW(MBW)) u_smul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_p)
    );

    always_comb begin
        err_s   = c_ang - (ZW'(hd_reg) <<< ERR_SH);
        err_a   = (err_s < 0) ? -err_s : err_s;
        err_rnd = {1'b0, err_a} + ((ZW+1)'(1) << (ERR_SH - 1));
        dist_sum = {1'b0, mul_p} + ((MPW+1)'(1) << (DIST_SH - 1));
        spd_sum  = {1'b0, mul_p} + ((MPW+1)'(1) << (FRACTION_BITS - 1));
        spd      = spd_sum[MPW:FRACTION_BITS];

        state_next   = state_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        err_next     = err_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        c_start      = 1'b0;
        mul_start    = 1'b0;
        mul_a        = XW'(c_mag);
        mul_b        = INV_GAIN;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        res_next = '0;
                        if (rx > 0 && rx < GOAL_LIM && ry > 0 && ry < GOAL_LIM) begin
                            goal_x_next = rx[15:0];
                            goal_y_next = ry[15:0];
                            res_next[31] = 1'b1;
                        end
                        state_next = ST_DONE;
                    end else begin
                        c_start    = 1'b1;
                        state_next = ST_CORD;
                    end
                end
            end
            ST_CORD: begin
                if (c_done) begin
                    err_next   = err_rnd[ZW:ERR_SH];
                    mul_start  = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul_done) begin
                    res_next  = '0;
                    if (dist_sum[MPW:DIST_SH] <= DIST_MIN) begin
                        state_next = ST_DONE;
                    end else if (err_reg > ERR_MIN) begin
                        res_next[30:16] = err_reg[14:0];
                        state_next = ST_DONE;
                    end else begin
                        mul_a      = XW'(dist_sum[MPW:DIST_SH]);
                        mul_b      = MBW'(gain_reg);
                        mul_start  = 1'b1;
                        state_next = ST_MUL2;
                    end
                end
            end
            ST_MUL2: begin
                if (mul_done) begin
                    res_next = '0;
                    if (spd > (MPW-FRACTION_BITS+1)'(limit_reg)) begin
                        res_next[15:0] = limit_reg;
                    end else begin
                        res_next[15:0] = spd[15:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            gain_reg    <= ONE;
            limit_reg   <= ONE;
            goal_x_reg  <= ONE;
            goal_y_reg  <= ONE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            goal_x_reg  <= goal_x_next;
            goal_y_reg  <= goal_y_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN:  gain_reg  <= cfg_data;
                    REG_LIMIT: limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (c_start) begin
            hd_reg <= s_tdata[46:32];
        end
        err_reg    <= err_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

### tb/gtg_checker.sv
// ----------------------------------------------------------------------------
// gtg_checker
// Watches the input, result and register channels of the go-to-goal block,
// computes the velocity command each accepted beat should produce and
// compares every result beat against the oldest pending command.
// ----------------------------------------------------------------------------
module gtg_checker import gtg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        acc;
        logic [14:0] turn;
        logic [15:0] speed;
    } cmd_t;

    localparam longint PI_L  = 64'sd3373259426;
    localparam longint IGAIN = 64'sd652032875;

    logic [15:0] gain_r, limit_r, goal_x, goal_y;
    cmd_t        cmd_q[$];

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic cmd_t velocity_cmd(logic [87:0] d, logic cmdb);
        cmd_t   c;
        longint rx, ry, x, y, z, xs, ys, dist_v, err, p;
        c = '0;
        if (cmdb) begin
            rx = longint'($signed(d[63:47]));
            ry = longint'($signed(d[80:64]));
            if (rx > 0 && rx < 49152 && ry > 0 && ry < 49152) begin
                goal_x = rx[15:0];
                goal_y = ry[15:0];
                c.acc = 1'b1;
            end
        end else begin
            x = (longint'(goal_x) - longint'(d[15:0])) * 256;
            y = (longint'(goal_y) - longint'(d[31:16])) * 256;
            z = 0;
            if (x < 0) begin
                z = (y >= 0) ? PI_L : -PI_L;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (y < 0) begin
                    x = x - ys; y = y + xs; z = z - longint'(atan_q30(i[4:0]));
                end else begin
                    x = x + ys; y = y - xs; z = z + longint'(atan_q30(i[4:0]));
                end
            end
            dist_v = (x * IGAIN + (64'sd1 <<< 37)) >>> 38;
            err = z - longint'($signed(d[46:32])) * (64'sd1 <<< 18);
            if (err < 0) err = -err;
            err = (err + (64'sd1 <<< 17)) >>> 18;
            if (dist_v > 410) begin
                if (err > 819) begin
                    c.turn = err[14:0];
                end else begin
                    p = (longint'(gain_r) * dist_v + 2048) >>> 12;
                    c.speed = (p > longint'(limit_r)) ? limit_r : p[15:0];
                end
            end
        end
        return c;
    endfunction

    always @(posedge aclk) begin
        cmd_t got, exp_c;
        int   errs;
        errs = 0;
        if (!aresetn) begin
            gain_r  <= ONE;
            limit_r <= ONE;
            goal_x  = ONE;
            goal_y  = ONE;
            cmd_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_GAIN) gain_r <= cfg_data;
                else if (cfg_index == REG_LIMIT) limit_r <= cfg_data;
            end
            if (s_tvalid && s_tready) cmd_q.push_back(velocity_cmd(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (cmd_q.size() == 0) begin
                    $error("result beat with nothing pending: %h", m_tdata);
                    errs++;
                end else begin
                    exp_c = cmd_q.pop_front();
                    if (got.speed !== exp_c.speed) begin
                        $error("linear_speed exp %0d got %0d", exp_c.speed, got.speed);
                        errs++;
                    end
                    if (got.turn !== exp_c.turn) begin
                        $error("turn_rate exp %0d got %0d", exp_c.turn, got.turn);
                        errs++;
                    end
                    if (got.acc !== exp_c.acc) begin
                        $error("accepted exp %0d got %0d", exp_c.acc, got.acc);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending <= cmd_q.size();
    end
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the go-to-goal block with directed and random pose and set-target
// beats under random idling and a long output stall, reprograms gain and
// speed limit between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top import gtg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid, m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0, cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending;
    int          cycles = 0;
    bit          stall_long = 1'b0;

    always #1 aclk = ~aclk;

    go_to_goal_velocity_controller u_top (.*);
    gtg_checker u_chk (.*);

    function automatic logic [87:0] pack_beat(logic [15:0] px, logic [15:0] py,
                                              logic [14:0] hd, logic [16:0] rx,
                                              logic [16:0] ry);
        return {7'h0, ry, rx, hd, py, px};
    endfunction

    task automatic send_beat(logic cmdb, logic [87:0] d);
        repeat ($urandom_range(0, 6)) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmdb;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    task automatic set_goal(logic [16:0] rx, logic [16:0] ry);
        send_beat(1'b1, pack_beat(16'($urandom), 16'($urandom), 15'($urandom), rx, ry));
    endtask

    task automatic pose(logic [15:0] px, logic [15:0] py, logic [14:0] hd);
        send_beat(1'b0, pack_beat(px, py, hd, 17'($urandom), 17'($urandom)));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending != 0 || s_tvalid) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic random_phase(int n);
        logic [15:0] gx, gy;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: set_goal(17'($urandom), 17'($urandom));
                1: set_goal(17'($urandom_range(1, 49151)), 17'($urandom_range(1, 49151)));
                2: pose(16'($urandom), 16'($urandom), 15'($urandom));
                default: begin
                    gx = u_chk.goal_x;
                    gy = u_chk.goal_y;
                    pose(gx + 16'($signed($urandom_range(0, 2000)) - 1000),
                         gy + 16'($signed($urandom_range(0, 2000)) - 1000),
                         15'($signed($urandom_range(0, 25736)) - 12868));
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("FAIL go_to_goal_velocity_controller");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_long) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 6) == 0) || ($urandom_range(0, 3) != 0);
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        pose(16'h1000, 16'h1000, 15'h0);
        pose(16'h0000, 16'h0000, 15'h0);
        pose(16'hFFFF, 16'hFFFF, 15'h7FFF);
        pose(16'hFFFF, 16'h0000, 15'h4000);
        pose(16'h0000, 16'hFFFF, -15'sd12868);
        pose(16'h2000, 16'h1000, 15'sd12868);
        pose(16'h1000, 16'h0F80, 15'h0);
        set_goal(17'h0, 17'h1000);
        set_goal(17'h1000, 17'h0C000);
        set_goal(17'h1FFFF, 17'h0FFFF);
        set_goal(17'h10000, 17'h1000);
        set_goal(17'h0BFFF, 17'h00001);
        pose(16'h0000, 16'h0000, 15'h0);
        pose(16'hBFFF, 16'h0800, 15'h0);
        set_goal(17'h05000, 17'h05000);
        pose(16'h0000, 16'h0000, 15'sd3217);
        pose(16'h4000, 16'h5000, 15'h0);
        drain();
        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_LIMIT, 16'hFFFF);
        fork
            random_phase(60);
            begin
                stall_long = 1'b1;
                repeat (600) @(posedge aclk);
                stall_long = 1'b0;
            end
        join
        random_phase(250);
        drain();
        write_reg(REG_GAIN, 16'h0000);
        write_reg(REG_LIMIT, 16'h0000);
        write_reg(2'd3, 16'h1234);
        random_phase(100);
        drain();
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_GAIN, 16'($urandom));
            write_reg(REG_LIMIT, 16'($urandom));
            random_phase(120);
            drain();
        end
        if (fail_count == 0) begin
            $display("PASS go_to_goal_velocity_controller");
        end else begin
            $display("FAIL go_to_goal_velocity_controller");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/gtg_pkg.sv
rtl/gtg_smul.sv
rtl/gtg_cordic.sv
rtl/go_to_goal_velocity_controller.sv
tb/gtg_checker.sv
tb/tb_top.sv
